// ===== hdl/gag_pkg.sv =====
// Shared types and constants for the generations automaton grid engine.
// Used by the sequencer, the datapath, the top level and the checker.
package gag_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int CFG_W      = 9;
  localparam int LEVEL_W    = 8;
  localparam int COUNT_W    = 4;
  localparam int POS_W      = 8;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ADDR_W     = 1 + ROW_W + COL_W;
  localparam int UPC_W      = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // level codes
  localparam logic [LEVEL_W-1:0] LEVEL_DEAD  = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] LEVEL_ALIVE = LEVEL_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_STATES  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = CFG_IDX_W'(4);

  // configuration reset values
  localparam logic [CFG_W-1:0] BIRTH_RST   = CFG_W'(8);
  localparam logic [CFG_W-1:0] SURVIVE_RST = CFG_W'(12);
  localparam logic [CFG_W-1:0] STATES_RST  = CFG_W'(2);
  localparam logic [CFG_W-1:0] STATES_MIN  = CFG_W'(2);
  localparam logic [CFG_W-1:0] WIDTH_RST   = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] HEIGHT_RST  = CFG_W'(MAX_HEIGHT);

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_COMMIT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ROW_MID,
    ROW_UP,
    ROW_DOWN
  } row_sel_t;

  typedef enum logic [1:0] {
    COL_MID,
    COL_LEFT,
    COL_RIGHT
  } col_sel_t;

  typedef enum logic [1:0] {
    MEM_NONE,
    MEM_READ,
    MEM_WR_CUR,
    MEM_WR_NEXT
  } mem_op_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ECHO,
    RES_READ,
    RES_UPDATE
  } res_sel_t;

  typedef enum logic [1:0] {
    NX_STEP,
    NX_FETCH,
    NX_DISPATCH
  } next_t;

  // one microcode control word
  typedef struct packed {
    logic     fetch;
    row_sel_t row_sel;
    col_sel_t col_sel;
    mem_op_t  mem_op;
    logic     cnt_en;
    res_sel_t res_sel;
    logic     emit;
    logic     flip;
    next_t    nxt;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    kind_t kind;
    logic  in_range;
    logic  in_valid;
    logic  out_busy;
  } status_t;

  // effective configuration, already clamped
  typedef struct packed {
    logic [CFG_W-1:0] birth_mask;
    logic [CFG_W-1:0] survive_mask;
    logic [CFG_W-1:0] num_states;
    logic [CFG_W-1:0] grid_width;
    logic [CFG_W-1:0] grid_height;
  } cfg_t;

endpackage

// ===== hdl/gag_sequencer.sv =====
// Microcode sequencer: step counter, control-word ROM and dispatch by item kind.
// Depends on gag_pkg.
module gag_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  gag_pkg::status_t status,
  output gag_pkg::ctrl_t   ctrl
);
  import gag_pkg::*;

  localparam logic [UPC_W-1:0] LBL_FETCH  = UPC_W'(0);
  localparam logic [UPC_W-1:0] LBL_WRITE  = UPC_W'(1);
  localparam logic [UPC_W-1:0] LBL_READ   = UPC_W'(2);
  localparam logic [UPC_W-1:0] LBL_UPDATE = UPC_W'(4);
  localparam logic [UPC_W-1:0] LBL_COMMIT = UPC_W'(14);
  localparam logic [UPC_W-1:0] LBL_ZERO   = UPC_W'(15);

  function automatic ctrl_t ucode_word(input logic [UPC_W-1:0] pc);
    ctrl_t w;
    w = '{fetch: 1'b0, row_sel: ROW_MID, col_sel: COL_MID, mem_op: MEM_NONE,
          cnt_en: 1'b0, res_sel: RES_ZERO, emit: 1'b0, flip: 1'b0, nxt: NX_STEP};
    case (pc)
      4'd0: begin w.fetch = 1'b1; w.nxt = NX_DISPATCH; end
      4'd1: begin
        w.mem_op = MEM_WR_CUR; w.res_sel = RES_ECHO; w.emit = 1'b1; w.nxt = NX_FETCH;
      end
      4'd2: begin w.mem_op = MEM_READ; end
      4'd3: begin w.res_sel = RES_READ; w.emit = 1'b1; w.nxt = NX_FETCH; end
      // eight neighbors, then the center; each count uses the previous read
      4'd4: begin w.row_sel = ROW_UP;   w.col_sel = COL_LEFT;  w.mem_op = MEM_READ; end
      4'd5: begin
        w.row_sel = ROW_UP;   w.col_sel = COL_MID;   w.mem_op = MEM_READ; w.cnt_en = 1'b1;
      end
      4'd6: begin
        w.row_sel = ROW_UP;   w.col_sel = COL_RIGHT; w.mem_op = MEM_READ; w.cnt_en = 1'b1;
      end
      4'd7: begin
        w.row_sel = ROW_MID;  w.col_sel = COL_LEFT;  w.mem_op = MEM_READ; w.cnt_en = 1'b1;
      end
      4'd8: begin
        w.row_sel = ROW_MID;  w.col_sel = COL_RIGHT; w.mem_op = MEM_READ; w.cnt_en = 1'b1;
      end
      4'd9: begin
        w.row_sel = ROW_DOWN; w.col_sel = COL_LEFT;  w.mem_op = MEM_READ; w.cnt_en = 1'b1;
      end
      4'd10: begin
        w.row_sel = ROW_DOWN; w.col_sel = COL_MID;   w.mem_op = MEM_READ; w.cnt_en = 1'b1;
      end
      4'd11: begin
        w.row_sel = ROW_DOWN; w.col_sel = COL_RIGHT; w.mem_op = MEM_READ; w.cnt_en = 1'b1;
      end
      4'd12: begin w.mem_op = MEM_READ; w.cnt_en = 1'b1; end
      4'd13: begin
        w.mem_op = MEM_WR_NEXT; w.res_sel = RES_UPDATE; w.emit = 1'b1; w.nxt = NX_FETCH;
      end
      4'd14: begin w.flip = 1'b1; w.emit = 1'b1; w.nxt = NX_FETCH; end
      default: begin w.emit = 1'b1; w.nxt = NX_FETCH; end
    endcase
    return w;
  endfunction

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  ctrl_t            word;
  logic             go;

  assign word = ucode_word(upc);
  // hold the step while the result register is still full
  assign go   = !(word.emit && status.out_busy);

  always_comb begin
    upc_next = upc;
    unique case (word.nxt)
      NX_DISPATCH: begin
        if (status.in_valid) begin
          if (status.kind == KIND_COMMIT) begin
            upc_next = LBL_COMMIT;
          end else if (!status.in_range) begin
            upc_next = LBL_ZERO;
          end else begin
            unique case (status.kind)
              KIND_WRITE: upc_next = LBL_WRITE;
              KIND_READ:  upc_next = LBL_READ;
              default:    upc_next = LBL_UPDATE;
            endcase
          end
        end
      end
      NX_STEP:  upc_next = go ? upc + UPC_W'(1) : upc;
      NX_FETCH: upc_next = go ? LBL_FETCH : upc;
      default:  upc_next = LBL_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= LBL_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  // drop all side effects of a stalled step
  always_comb begin
    ctrl = word;
    if (!go) begin
      ctrl.mem_op = MEM_NONE;
      ctrl.cnt_en = 1'b0;
      ctrl.emit   = 1'b0;
      ctrl.flip   = 1'b0;
    end
  end

endmodule

// ===== hdl/gag_datapath.sv =====
// Datapath: item register, wrapped address generation, double-buffered frame
// memory, neighbor counter, next-level rule and result register. Depends on gag_pkg.
module gag_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  gag_pkg::ctrl_t                    ctrl,
  input  gag_pkg::cfg_t                     cfg,
  input  logic                              s_tvalid,
  input  logic [gag_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [1:0]                        s_tuser,
  output gag_pkg::status_t                  status,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gag_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import gag_pkg::*;

  logic [POS_W-1:0]   in_row;
  logic [POS_W-1:0]   in_col;
  logic [LEVEL_W-1:0] in_level;

  logic [POS_W-1:0]   row;
  logic [POS_W-1:0]   col;
  logic [LEVEL_W-1:0] cell_level;
  logic [COUNT_W-1:0] count;
  logic               cur_b;

  logic [POS_W-1:0]   row_sel;
  logic [POS_W-1:0]   col_sel;
  logic [CFG_W-1:0]   row_inc;
  logic [CFG_W-1:0]   col_inc;
  logic               bank;
  logic [ADDR_W-1:0]  addr;
  logic [LEVEL_W-1:0] wr_data;

  logic [LEVEL_W-1:0] mem [2**ADDR_W];
  logic [LEVEL_W-1:0] rd_data;

  logic [LEVEL_W:0]   lvl_inc;
  logic [LEVEL_W-1:0] new_level;

  logic [LEVEL_W-1:0] res_level;
  logic [COUNT_W-1:0] res_count;
  logic [LEVEL_W-1:0] level_out;
  logic [COUNT_W-1:0] alive_neighbours;

  assign in_row   = s_tdata[POS_W-1:0];
  assign in_col   = s_tdata[2*POS_W-1:POS_W];
  assign in_level = s_tdata[2*POS_W+LEVEL_W-1:2*POS_W];

  assign status.kind     = kind_t'(s_tuser);
  assign status.in_range = ({1'b0, in_row} < cfg.grid_height) &&
                           ({1'b0, in_col} < cfg.grid_width);
  assign status.in_valid = s_tvalid;
  assign status.out_busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (ctrl.fetch && s_tvalid) begin
      row        <= in_row;
      col        <= in_col;
      cell_level <= in_level;
    end
  end

  // wrapped neighbor coordinates
  assign row_inc = {1'b0, row} + CFG_W'(1);
  assign col_inc = {1'b0, col} + CFG_W'(1);

  always_comb begin
    unique case (ctrl.row_sel)
      ROW_UP:   row_sel = (row == '0) ? POS_W'(cfg.grid_height - CFG_W'(1)) : row - POS_W'(1);
      ROW_DOWN: row_sel = (row_inc >= cfg.grid_height) ? '0 : row_inc[POS_W-1:0];
      default:  row_sel = row;
    endcase
    unique case (ctrl.col_sel)
      COL_LEFT:  col_sel = (col == '0) ? POS_W'(cfg.grid_width - CFG_W'(1)) : col - POS_W'(1);
      COL_RIGHT: col_sel = (col_inc >= cfg.grid_width) ? '0 : col_inc[POS_W-1:0];
      default:   col_sel = col;
    endcase
  end

  assign bank    = (ctrl.mem_op == MEM_WR_NEXT) ? !cur_b : cur_b;
  assign addr    = {bank, row_sel[ROW_W-1:0], col_sel[COL_W-1:0]};
  assign wr_data = (ctrl.mem_op == MEM_WR_NEXT) ? new_level : cell_level;

  // single-port frame memory, both frames side by side
  always_ff @(posedge clk) begin
    if (ctrl.mem_op == MEM_WR_CUR || ctrl.mem_op == MEM_WR_NEXT) begin
      mem[addr] <= wr_data;
    end
    if (ctrl.mem_op == MEM_READ) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fetch) begin
      count <= '0;
    end else if (ctrl.cnt_en && rd_data == LEVEL_ALIVE) begin
      count <= count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_b <= 1'b0;
    end else if (ctrl.flip) begin
      cur_b <= !cur_b;
    end
  end

  // next-level rule; rd_data holds the center cell here
  assign lvl_inc = {1'b0, rd_data} + (LEVEL_W+1)'(1);

  always_comb begin
    if (rd_data == LEVEL_DEAD) begin
      new_level = cfg.birth_mask[count] ? LEVEL_ALIVE : LEVEL_DEAD;
    end else if (rd_data == LEVEL_ALIVE && cfg.survive_mask[count]) begin
      new_level = LEVEL_ALIVE;
    end else if (lvl_inc >= cfg.num_states) begin
      new_level = LEVEL_DEAD;
    end else begin
      new_level = lvl_inc[LEVEL_W-1:0];
    end
  end

  always_comb begin
    res_count = '0;
    case (ctrl.res_sel)
      RES_ECHO:   res_level = cell_level;
      RES_READ:   res_level = rd_data;
      RES_UPDATE: begin
        res_level = new_level;
        res_count = count;
      end
      default:    res_level = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      level_out        <= res_level;
      alive_neighbours <= res_count;
    end
  end

  assign m_tdata = {(OUT_DATA_W-LEVEL_W-COUNT_W)'(0), alive_neighbours, level_out};

endmodule

// ===== hdl/generations_automaton_grid_unit.sv =====
// Generations automaton grid engine, top level. One item at a time; an item's
// result step waits while the result register is still full. Throughput is set by
// the single-port frame memory, which an update visits nine times (eight neighbors,
// then the center) plus one write-back.
// Reset (rst, synchronous) clears the sequencer, result valid, the frame select and
// the configuration registers; frame contents are not cleared.
module generations_automaton_grid_unit (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [gag_pkg::IN_DATA_W-1:0]     s_tdata,   // row[7:0], col[15:8], cell_level[23:16]
  input  logic [1:0]                        s_tuser,   // kind[1:0]
  // results
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gag_pkg::OUT_DATA_W-1:0]    m_tdata,   // level_out[7:0], alive_neighbours[11:8]
  // configuration writes
  input  logic                              cfg_we,
  input  logic [gag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gag_pkg::CFG_W-1:0]         cfg_data
);
  import gag_pkg::*;

  logic [CFG_W-1:0] birth_mask;
  logic [CFG_W-1:0] survive_mask;
  logic [CFG_W-1:0] num_states;
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;

  cfg_t    cfg;
  ctrl_t   ctrl;
  status_t status;

  // configuration register file; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      birth_mask   <= BIRTH_RST;
      survive_mask <= SURVIVE_RST;
      num_states   <= STATES_RST;
      grid_width   <= WIDTH_RST;
      grid_height  <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIRTH:   birth_mask   <= cfg_data;
        CFG_SURVIVE: survive_mask <= cfg_data;
        CFG_STATES:  num_states   <= cfg_data;
        CFG_WIDTH:   grid_width   <= cfg_data;
        CFG_HEIGHT:  grid_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp: fewer than two states act as two, a zero size acts as one,
  // an oversize dimension saturates at the frame size
  always_comb begin
    cfg.birth_mask   = birth_mask;
    cfg.survive_mask = survive_mask;
    cfg.num_states   = (num_states < STATES_MIN) ? STATES_MIN : num_states;
    if (grid_width == '0) begin
      cfg.grid_width = CFG_W'(1);
    end else if (grid_width > CFG_W'(MAX_WIDTH)) begin
      cfg.grid_width = CFG_W'(MAX_WIDTH);
    end else begin
      cfg.grid_width = grid_width;
    end
    if (grid_height == '0) begin
      cfg.grid_height = CFG_W'(1);
    end else if (grid_height > CFG_W'(MAX_HEIGHT)) begin
      cfg.grid_height = CFG_W'(MAX_HEIGHT);
    end else begin
      cfg.grid_height = grid_height;
    end
  end

  // take a new item only at the dispatch step, never while in reset
  assign s_tready = ctrl.fetch && !rst;

  gag_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  gag_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== hdl/gag_checker.sv =====
// Port-level checker for the grid engine, bound to the top level.
// Depends on gag_pkg.
module gag_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [gag_pkg::OUT_DATA_W-1:0]    m_tdata,
  input logic                              m_tvalid,
  input logic                              m_tready
);
  import gag_pkg::*;

  // a waiting result holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed or vanished");

  // one item at a time: no transfer right after a transfer
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while previous item still in work");

  // at most eight neighbors counted
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[LEVEL_W+COUNT_W-1:LEVEL_W] <= COUNT_W'(8)))
    else $error("neighbor count above eight");

  // reset empties the result register
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind generations_automaton_grid_unit gag_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

// ===== test/generations_automaton_grid_unit_tb.sv =====
// Self-checking testbench for generations_automaton_grid_unit: directed table, then random
// rule sets and grids. Needs gag_pkg and the unit; the expected values come from a
// behavioral grid model in this file, or from the table for its typed rows.
module generations_automaton_grid_unit_tb;
  import gag_pkg::*;

  localparam int RANDOM_ITEMS     = 1700;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int CELL_COUNT       = MAX_WIDTH * MAX_HEIGHT;
  localparam int NUM_PLAN         = 31;

  // One result transfer: level_out and the alive neighbor count.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [COUNT_W-1:0] alive_count;
  } result_t;

  // One row of the directed table: a register write or an input item.
  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    kind_t                kind;
    logic [POS_W-1:0]     row;
    logic [POS_W-1:0]     col;
    logic [LEVEL_W-1:0]   level;
    logic                 typed;
    result_t              want;
  } step_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;    // row[7:0], col[15:8], cell_level[23:16]
  logic [1:0]            s_tuser;    // kind[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;    // level_out[7:0], alive_neighbours[11:8]
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  generations_automaton_grid_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Grid model: both frames, a written flag per cell, the frame select and the
  // rule registers as the unit should hold them.
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0] cell_mem   [0:1][0:CELL_COUNT-1];
  bit                 cell_known [0:1][0:CELL_COUNT-1];
  bit                 cur_frame;
  logic [CFG_W-1:0]   birth_rule;
  logic [CFG_W-1:0]   survive_rule;
  logic [CFG_W-1:0]   states_reg;
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;

  result_t   expected_levels [$];
  step_row_t plan [0:NUM_PLAN-1];

  int items_sent;
  int results_seen;
  int mismatches;
  int n_writes, n_reads, n_updates, n_commits;
  int rule_sets;
  int cycle_count;
  int burst_left;
  bit calm_stretch;
  int rx_cycle = 0;
  int rx_mode  = 0;

  function automatic int eff_cols();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int eff_rows();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  function automatic int eff_states();
    if (states_reg < STATES_MIN) return int'(STATES_MIN);
    return int'(states_reg);
  endfunction

  function automatic int cell_addr(int r, int c);
    return r * MAX_WIDTH + c;
  endfunction

  // Apply one item to the grid model and return the result it must produce.
  function automatic result_t apply_grid_item(kind_t kind, logic [POS_W-1:0] row,
                                              logic [POS_W-1:0] col,
                                              logic [LEVEL_W-1:0] level);
    result_t            res;
    int                 h, w, ns, addr, alive, nxt, i, j;
    int                 rr [0:2];
    int                 cc [0:2];
    logic [LEVEL_W-1:0] centre;
    res = '0;
    h   = eff_rows();
    w   = eff_cols();
    ns  = eff_states();
    case (kind)
      KIND_WRITE:  n_writes++;
      KIND_READ:   n_reads++;
      KIND_UPDATE: n_updates++;
      default:     n_commits++;
    endcase
    if (kind == KIND_COMMIT) begin
      cur_frame = !cur_frame;
      return res;
    end
    // outside the grid: nothing stored, nothing read, zeros back
    if (int'(row) >= h || int'(col) >= w) return res;
    addr = cell_addr(int'(row), int'(col));
    if (kind == KIND_WRITE) begin
      cell_mem[cur_frame][addr]   = level;
      cell_known[cur_frame][addr] = 1'b1;
      res.level = level;
    end else if (kind == KIND_READ) begin
      res.level = cell_mem[cur_frame][addr];
    end else begin
      // wrapped neighborhood on the torus
      rr[0] = (row == 0) ? h - 1 : int'(row) - 1;
      rr[1] = int'(row);
      rr[2] = (int'(row) + 1 >= h) ? 0 : int'(row) + 1;
      cc[0] = (col == 0) ? w - 1 : int'(col) - 1;
      cc[1] = int'(col);
      cc[2] = (int'(col) + 1 >= w) ? 0 : int'(col) + 1;
      alive = 0;
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3; j++)
          if (!(i == 1 && j == 1) &&
              cell_mem[cur_frame][cell_addr(rr[i], cc[j])] == LEVEL_ALIVE)
            alive++;
      centre = cell_mem[cur_frame][addr];
      if (centre == LEVEL_DEAD) begin
        nxt = birth_rule[alive] ? 1 : 0;
      end else if (centre == LEVEL_ALIVE && survive_rule[alive]) begin
        nxt = 1;
      end else begin
        // dying, or a level at or past num_states: step and wrap to dead
        nxt = int'(centre) + 1;
        if (nxt >= ns) nxt = 0;
      end
      cell_mem[!cur_frame][addr]   = LEVEL_W'(nxt);
      cell_known[!cur_frame][addr] = 1'b1;
      res.level       = LEVEL_W'(nxt);
      res.alive_count = COUNT_W'(alive);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Push one item through the input port. The sender works in bursts; between
  // bursts drop tvalid for a random gap, except during calm stretches.
  task automatic send_item(input kind_t kind, input int row, input int col,
                           input int level, input bit typed = 1'b0,
                           input result_t want = '0);
    result_t            predicted;
    logic [POS_W-1:0]   row_b;
    logic [POS_W-1:0]   col_b;
    logic [LEVEL_W-1:0] level_b;
    int                 gap;
    row_b   = POS_W'(row);
    col_b   = POS_W'(col);
    level_b = LEVEL_W'(level);
    if (burst_left == 0) begin
      gap = calm_stretch ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    predicted = apply_grid_item(kind, row_b, col_b, level_b);
    expected_levels.insert(expected_levels.size(), typed ? want : predicted);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {level_b, col_b, row_b};
    do @(posedge clk); while (s_tready !== 1'b1);
    items_sent++;
    if (items_sent % 300 == 0) calm_stretch = ($urandom_range(0, 2) == 0);
  endtask

  // Hold the input side until every result has come back, then let the unit settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_BIRTH:   birth_rule   = val;
      CFG_SURVIVE: survive_rule = val;
      CFG_STATES:  states_reg   = val;
      CFG_WIDTH:   width_reg    = val;
      CFG_HEIGHT:  height_reg   = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_rules(input logic [CFG_W-1:0] birth, input logic [CFG_W-1:0] survive,
                            input logic [CFG_W-1:0] states, input logic [CFG_W-1:0] cols,
                            input logic [CFG_W-1:0] rows);
    wait_idle();
    set_reg(CFG_BIRTH, birth);
    set_reg(CFG_SURVIVE, survive);
    set_reg(CFG_STATES, states);
    set_reg(CFG_WIDTH, cols);
    set_reg(CFG_HEIGHT, rows);
    rule_sets++;
  endtask

  function automatic logic [CFG_W-1:0] pick_mask();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CFG_W'(9'h008);   // born on three
      3:       return CFG_W'(9'h004);   // born on two
      default: return CFG_W'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_states();
    case ($urandom_range(0, 9))
      0:       return CFG_W'(0);
      1:       return CFG_W'(1);
      2:       return CFG_W'(2);
      3:       return CFG_W'(255);
      4:       return CFG_W'(256);
      5:       return CFG_W'(511);
      default: return CFG_W'($urandom_range(3, 12));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_wide();
    if ($urandom_range(0, 2) == 0) return CFG_W'($urandom_range(257, 511));
    return CFG_W'($urandom_range(200, 256));
  endfunction

  // Mostly alive and dead, some dying stages, a few arbitrary levels.
  function automatic int rand_level();
    int ns, pick;
    ns   = eff_states();
    pick = $urandom_range(0, 19);
    if (pick < 9) return int'(LEVEL_ALIVE);
    if (pick < 14) return int'(LEVEL_DEAD);
    if (pick < 19) return (ns > 2) ? $urandom_range(2, (ns > 256) ? 255 : ns - 1)
                                   : int'(LEVEL_ALIVE);
    return $urandom_range(0, 255);
  endfunction

  // Favor the grid edges so the wrap paths see traffic.
  function automatic int edge_pick(int n);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 0 : n - 1;
    return $urandom_range(0, n - 1);
  endfunction

  // Read a cell if it holds a known level, otherwise write it.
  task automatic touch_cell(input int r, input int c);
    if (cell_known[cur_frame][cell_addr(r, c)])
      send_item(KIND_READ, r, c, $urandom_range(0, 255));
    else
      send_item(KIND_WRITE, r, c, rand_level());
  endtask

  // Update one cell; write first any neighbor whose level is still unknown.
  task automatic update_cell(input int r, input int c);
    int h, w, i, j;
    int rr [0:2];
    int cc [0:2];
    h = eff_rows();
    w = eff_cols();
    rr[0] = (r == 0) ? h - 1 : r - 1;
    rr[1] = r;
    rr[2] = (r + 1 >= h) ? 0 : r + 1;
    cc[0] = (c == 0) ? w - 1 : c - 1;
    cc[1] = c;
    cc[2] = (c + 1 >= w) ? 0 : c + 1;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        if (!cell_known[cur_frame][cell_addr(rr[i], cc[j])])
          send_item(KIND_WRITE, rr[i], cc[j], rand_level());
    send_item(KIND_UPDATE, r, c, $urandom_range(0, 255));
  endtask

  task automatic send_noise();
    int h, w, r, c;
    h = eff_rows();
    w = eff_cols();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: touch_cell($urandom_range(0, h - 1), $urandom_range(0, w - 1));
      4, 5: send_item(KIND_WRITE, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
                      rand_level());
      6, 7, 8: begin
        if (h == MAX_HEIGHT && w == MAX_WIDTH) begin
          touch_cell($urandom_range(0, h - 1), $urandom_range(0, w - 1));
        end else begin
          // cell outside the grid, any kind but commit
          if (h < MAX_HEIGHT && (w == MAX_WIDTH || $urandom_range(0, 1) == 1)) begin
            r = $urandom_range(h, 255);
            c = $urandom_range(0, 255);
          end else begin
            r = $urandom_range(0, 255);
            c = $urandom_range(w, 255);
          end
          send_item(kind_t'($urandom_range(0, 2)), r, c, $urandom_range(0, 255));
        end
      end
      default: send_item(KIND_COMMIT, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255));
    endcase
  endtask

  // One rule set. Small grids run whole generations: seed every cell, update every
  // cell, commit. Wide grids update scattered cells with their neighborhoods seeded.
  task automatic run_phase(input bit wide);
    int h, w, r, c;
    if (wide)
      load_rules(pick_mask(), pick_mask(), pick_states(), pick_wide(), pick_wide());
    else
      load_rules(pick_mask(), pick_mask(), pick_states(),
                 CFG_W'($urandom_range(0, 10)), CFG_W'($urandom_range(0, 10)));
    h = eff_rows();
    w = eff_cols();
    if (wide) begin
      repeat ($urandom_range(15, 40)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: update_cell(edge_pick(h), edge_pick(w));
          6, 7, 8: send_noise();
          default: send_item(KIND_COMMIT, $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
        endcase
      end
    end else begin
      for (r = 0; r < h; r++)
        for (c = 0; c < w; c++) begin
          if ($urandom_range(0, 9) == 0) send_noise();
          if (!cell_known[cur_frame][cell_addr(r, c)] || $urandom_range(0, 3) == 0)
            send_item(KIND_WRITE, r, c, rand_level());
        end
      repeat ($urandom_range(1, 3)) begin
        for (r = 0; r < h; r++)
          for (c = 0; c < w; c++) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            update_cell(r, c);
          end
        send_item(KIND_COMMIT, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
      end
    end
  endtask

  // Directed table row builders.
  function automatic step_row_t row_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    step_row_t s;
    s         = '0;
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_row_t row_item(kind_t kind, logic [POS_W-1:0] row,
                                        logic [POS_W-1:0] col, logic [LEVEL_W-1:0] level);
    step_row_t s;
    s       = '0;
    s.kind  = kind;
    s.row   = row;
    s.col   = col;
    s.level = level;
    return s;
  endfunction

  function automatic step_row_t row_check(kind_t kind, logic [POS_W-1:0] row,
                                         logic [POS_W-1:0] col, logic [LEVEL_W-1:0] level,
                                         logic [LEVEL_W-1:0] want_level);
    step_row_t s;
    s                  = row_item(kind, row, col, level);
    s.typed            = 1'b1;
    s.want.level       = want_level;
    s.want.alive_count = '0;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern picked at random from four modes, and check every
  // result transfer against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 128 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (rx_cycle % 8 < 5);
    endcase
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      results_seen++;
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("result with nothing expected: level %0d count %0d",
                   m_tdata[7:0], m_tdata[11:8]);
      end else begin
        want = expected_levels.pop_front();
        if (m_tdata[7:0] !== want.level || m_tdata[11:8] !== want.alive_count) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("result %0d mismatch: level exp %0d got %0d, count exp %0d got %0d",
                     results_seen, want.level, m_tdata[7:0], want.alive_count,
                     m_tdata[11:8]);
        end
      end
    end
  end

  // Watchdog: end the run if the unit hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_levels.size());
      $display("** generations_automaton_grid_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int k, random_start, phase;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    cur_frame    = 1'b0;
    birth_rule   = BIRTH_RST;
    survive_rule = SURVIVE_RST;
    states_reg   = STATES_RST;
    width_reg    = WIDTH_RST;
    height_reg   = HEIGHT_RST;
    burst_left   = 0;
    calm_stretch = 1'b0;
    rule_sets    = 1;

    // Directed table. Rows with a typed value are obvious from the rules; the
    // rest go through the grid model.
    plan = '{
      // reset rules, full 256 x 256 torus: corners and extreme levels
      row_check(KIND_WRITE, 0, 0, 1, 1),
      row_check(KIND_WRITE, 255, 255, 255, 255),
      row_check(KIND_READ, 255, 255, 0, 255),
      // fill the wrapped neighborhood of (0,0), then update it
      row_item(KIND_WRITE, 255, 0, 1),
      row_item(KIND_WRITE, 255, 1, 0),
      row_item(KIND_WRITE, 0, 255, 1),
      row_item(KIND_WRITE, 0, 1, 1),
      row_item(KIND_WRITE, 1, 255, 0),
      row_item(KIND_WRITE, 1, 0, 0),
      row_item(KIND_WRITE, 1, 1, 1),
      row_item(KIND_UPDATE, 0, 0, 0),
      row_check(KIND_COMMIT, 0, 0, 0, 0),
      row_item(KIND_READ, 0, 0, 0),
      row_check(KIND_COMMIT, 255, 255, 255, 0),
      // zero width and height act as a one-cell grid
      row_reg(CFG_WIDTH, 0),
      row_reg(CFG_HEIGHT, 0),
      row_check(KIND_READ, 0, 1, 0, 0),
      row_check(KIND_WRITE, 5, 0, 7, 0),
      row_item(KIND_UPDATE, 0, 0, 0),
      // num_states below two acts as two
      row_reg(CFG_STATES, 0),
      row_check(KIND_COMMIT, 0, 0, 0, 0),
      row_item(KIND_UPDATE, 0, 0, 0),
      // stored level past num_states dies on update
      row_reg(CFG_STATES, 3),
      row_check(KIND_WRITE, 0, 0, 255, 255),
      row_check(KIND_UPDATE, 0, 0, 0, 0),
      // oversized width saturates, masks at their extremes
      row_reg(CFG_WIDTH, 511),
      row_reg(CFG_HEIGHT, 256),
      row_reg(CFG_BIRTH, 511),
      row_reg(CFG_SURVIVE, 0),
      row_check(KIND_WRITE, 200, 100, 0, 0),
      row_item(KIND_READ, 200, 100, 0)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < NUM_PLAN; k++) begin
      if (plan[k].is_reg) begin
        wait_idle();
        set_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        send_item(plan[k].kind, int'(plan[k].row), int'(plan[k].col),
                  int'(plan[k].level), plan[k].typed, plan[k].want);
      end
    end

    // Random rule sets until the item budget is spent; every fifth and some more are wide.
    random_start = items_sent;
    phase        = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      run_phase(phase % 5 == 1 || $urandom_range(0, 7) == 0);
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk);

    $display("Ran %0d items (%0d writes, %0d reads, %0d updates, %0d commits)",
             items_sent, n_writes, n_reads, n_updates, n_commits);
    $display("under %0d rule sets; %0d results checked, %0d mismatches.",
             rule_sets, results_seen, mismatches);
    if (mismatches == 0 && expected_levels.size() == 0)
      $display("** generations_automaton_grid_unit: PASSED **");
    else
      $display("** generations_automaton_grid_unit: FAILED **");
    $finish;
  end

endmodule
